### src/dilp_pkg.sv
// ----------------------------------------------------------------------------
// dilp_pkg: shared types and constants of the integer list parser
// Byte classes, scan phases, queue words and character codes used by the
// front classifier, the back accumulator and the top level.
// ----------------------------------------------------------------------------
package dilp_pkg;

  // default queue depths
  localparam int unsigned CLS_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // separator after reset is a comma
  localparam logic [7:0] SEP_RESET = 8'h2C;

  // character codes
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // magnitude ceiling and positive saturation value
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CLS_SEP,
    CLS_WHITE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } byte_cls_e;

  typedef enum logic [1:0] {
    PHASE_SPACE,
    PHASE_DIGITS,
    PHASE_DONE
  } scan_phase_e;

  // classified byte, front to back
  typedef struct packed {
    byte_cls_e  cls;
    logic [3:0] digit;
    logic       fin;
  } cls_word_t;

  // finished result, back to output queue
  typedef struct packed {
    logic [31:0] number;
    logic        end_of_list;
  } res_word_t;

  // token state summary from the back part
  typedef struct packed {
    logic token_started;
    logic phase_idle;
  } back_stat_t;

endpackage

### src/dilp_fifo.sv
// ----------------------------------------------------------------------------
// dilp_fifo: short register queue
// Circular buffer with push/full and pop/empty; holds DEPTH words.
// ----------------------------------------------------------------------------
module dilp_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/dilp_front.sv
// ----------------------------------------------------------------------------
// dilp_front: byte classifier
// Holds the separator register and sorts each incoming byte into a class
// word for the back part.
// ----------------------------------------------------------------------------
module dilp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic [7:0]          text_byte_i,
  input  logic                final_byte_i,
  output dilp_pkg::cls_word_t cls_word_o
);

  import dilp_pkg::*;

  logic [7:0] sep_q;

  // separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  // classify the byte, separator first
  always_comb begin
    cls_word_o.digit = text_byte_i[3:0];
    cls_word_o.fin   = final_byte_i;
    if (text_byte_i == sep_q) begin
      cls_word_o.cls = CLS_SEP;
    end else if (text_byte_i == CHAR_SPACE ||
                 (text_byte_i >= CHAR_TAB && text_byte_i <= CHAR_CR)) begin
      cls_word_o.cls = CLS_WHITE;
    end else if (text_byte_i == CHAR_PLUS) begin
      cls_word_o.cls = CLS_PLUS;
    end else if (text_byte_i == CHAR_MINUS) begin
      cls_word_o.cls = CLS_MINUS;
    end else if (text_byte_i >= CHAR_ZERO && text_byte_i <= CHAR_NINE) begin
      cls_word_o.cls = CLS_DIGIT;
    end else begin
      cls_word_o.cls = CLS_OTHER;
    end
  end

endmodule

### src/dilp_back.sv
// ----------------------------------------------------------------------------
// dilp_back: token accumulator
// Takes class words, runs the whitespace/sign/digit scan, accumulates the
// saturated magnitude and pushes finished values into the result queue.
// ----------------------------------------------------------------------------
module dilp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dilp_pkg::cls_word_t  cls_word_i,
  input  logic                 cls_empty_i,
  output logic                 cls_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output dilp_pkg::res_word_t  res_word_o,
  output dilp_pkg::back_stat_t stat_o
);

  import dilp_pkg::*;

  scan_phase_e phase_q, phase_d;
  logic        started_q, started_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic [35:0] mag_sum;
  logic [31:0] mag_acc;

  // signed value of a token, saturated
  function automatic logic [31:0] token_value(input logic neg, input logic [31:0] mag);
    logic [31:0] v;
    if (neg) begin
      v = (mag >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - mag);
    end else begin
      v = (mag >= MAG_LIMIT) ? INT_MAX : mag;
    end
    return v;
  endfunction

  // magnitude times ten plus digit, held at the limit
  assign mag_sum = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {32'd0, cls_word_i.digit};
  assign mag_acc = (mag_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_sum[31:0];

  // scan step
  always_comb begin
    phase_d    = phase_q;
    started_d  = started_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    cls_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_word_o.number      = token_value(neg_q, mag_q);
    res_word_o.end_of_list = cls_word_i.fin;
    if (!cls_empty_i && !res_full_i) begin
      cls_pop_o = 1'b1;
      if (cls_word_i.cls == CLS_SEP) begin
        // separator ends the token, empty tokens give nothing
        res_push_o = started_q;
        started_d  = 1'b0;
        phase_d    = PHASE_SPACE;
        neg_d      = 1'b0;
        mag_d      = '0;
      end else begin
        started_d = 1'b1;
        case (phase_q)
          PHASE_SPACE: begin
            case (cls_word_i.cls)
              CLS_WHITE: begin
              end
              CLS_PLUS: begin
                neg_d   = 1'b0;
                phase_d = PHASE_DIGITS;
              end
              CLS_MINUS: begin
                neg_d   = 1'b1;
                phase_d = PHASE_DIGITS;
              end
              CLS_DIGIT: begin
                phase_d = PHASE_DIGITS;
                mag_d   = mag_acc;
              end
              default: begin
                phase_d = PHASE_DONE;
              end
            endcase
          end
          PHASE_DIGITS: begin
            if (cls_word_i.cls == CLS_DIGIT) begin
              mag_d = mag_acc;
            end else begin
              phase_d = PHASE_DONE;
            end
          end
          default: begin
          end
        endcase
        // last byte of the string always emits the token
        res_word_o.number      = token_value(neg_d, mag_d);
        res_word_o.end_of_list = 1'b1;
        res_push_o             = cls_word_i.fin;
      end
      // back to reset state after the last byte
      if (cls_word_i.fin) begin
        started_d = 1'b0;
        phase_d   = PHASE_SPACE;
        neg_d     = 1'b0;
        mag_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_SPACE;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      mag_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      started_q <= started_d;
      neg_q     <= neg_d;
      mag_q     <= mag_d;
    end
  end

  // status summary
  assign stat_o.token_started = started_q;
  assign stat_o.phase_idle    = (phase_q == PHASE_SPACE) && !neg_q && (mag_q == '0);

endmodule

### src/delimited_integer_list_parser_top.sv
// ----------------------------------------------------------------------------
// delimited_integer_list_parser_top: delimited decimal integer list parser
// Splits a byte stream at a configurable separator and converts each
// non-empty token to a saturated signed 32-bit integer.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive text_byte_i and final_byte_i and raise
//   push; the word is taken at a clock edge where push is high and full is
//   low. Output side is a queue too: while empty is low, number_o and
//   end_of_list_o show the oldest result; pop takes it.
//   The separator is written through cfg_we_i / cfg_wdata_i while idle.
// Path: the word that ends a token is registered in the class queue, then
//   the back part pops it and writes the result, which is registered in
//   the result queue that drives the output ports.
// Throughput: one byte per cycle while the result queue is not full; the
//   combinational times-ten-plus-digit update in the back part sets this.
// Reset: both queues empty, token state cleared, separator set to comma.
// Stall: when pop stays low the result queue fills, the back part stops
//   taking class words, the class queue fills and full rises.
// ----------------------------------------------------------------------------
module delimited_integer_list_parser_top #(
  parameter int unsigned CLS_QUEUE_DEPTH = dilp_pkg::CLS_DEPTH,
  parameter int unsigned RES_QUEUE_DEPTH = dilp_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] number_o,
  output logic        end_of_list_o
);

  import dilp_pkg::*;

  cls_word_t  cls_in, cls_out;
  logic       cls_empty, cls_pop;
  res_word_t  res_in, res_out;
  logic       res_push, res_full;
  back_stat_t stat;

  // classify incoming bytes
  dilp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .text_byte_i (text_byte_i),
    .final_byte_i(final_byte_i),
    .cls_word_o  (cls_in)
  );

  // queue between front and back
  dilp_fifo #(
    .DATA_W($bits(cls_word_t)),
    .DEPTH (CLS_QUEUE_DEPTH)
  ) u_cls_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_in),
    .full_o (full),
    .pop_i  (cls_pop),
    .data_o (cls_out),
    .empty_o(cls_empty)
  );

  // token scan and accumulate
  dilp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_word_i (cls_out),
    .cls_empty_i(cls_empty),
    .cls_pop_o  (cls_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_word_o (res_in),
    .stat_o     (stat)
  );

  // result queue toward the receiver
  dilp_fifo #(
    .DATA_W($bits(res_word_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign number_o      = res_out.number;
  assign end_of_list_o = res_out.end_of_list;

`ifndef SYNTHESIS
  // back part never consumes a word it could not deliver
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_pop |-> !res_full)
    else $error("class word taken while result queue full");

  // token state is clean after the last byte of a string
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_pop && cls_out.fin) |=> (!stat.token_started && stat.phase_idle))
    else $error("token state not cleared after final byte");

  // an empty token gives no result
  a_empty_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_pop && cls_out.cls == CLS_SEP && !stat.token_started) |-> !res_push)
    else $error("result pushed for empty token");

  // a final non-separator byte always gives a result
  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_pop && cls_out.fin && cls_out.cls != CLS_SEP) |-> (res_push && res_in.end_of_list))
    else $error("final byte did not emit a result");
`endif

endmodule
